>>> src/vas_pkg.sv
package vas_pkg;

	localparam int unsigned DATA_W    = 16;
	localparam int unsigned CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVATE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_ON   = 2'd3;

	// sequencer states, one-hot
	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SQ   = 11'b000_0000_0010,
		ST_ADD  = 11'b000_0000_0100,
		ST_A2   = 11'b000_0000_1000,
		ST_AL   = 11'b000_0001_0000,
		ST_AH   = 11'b000_0010_0000,
		ST_AC   = 11'b000_0100_0000,
		ST_RL   = 11'b000_1000_0000,
		ST_RH   = 11'b001_0000_0000,
		ST_RC   = 11'b010_0000_0000,
		ST_DEC  = 11'b100_0000_0000
	} st_t;

endpackage

>>> src/voice_activity_switch_rms.sv
// voice operated switch with rms hysteresis, minimum on-time and hangover. one beat on the
// input carries one signed audio sample and a frame_end flag on the last sample of a frame.
// squares of the samples are summed and counted; at frame end the frame rms is tested
// against activate_level and the lower release_level (q0.16 of full scale) without a root,
// as 4*sum > level^2*count and 4*sum < level^2*count, the switch state, minimum-on and
// hangover countdowns and the wrapping activation count are updated and one result beat is
// sent. samples past FRAME_MAX in a frame are dropped and flagged in frame_overflow. all
// arithmetic goes through one shared 16 x max(16,count width) multiplier under a small
// sequencer: a sample is accepted, squared and accumulated; a frame-end sample then builds
// level^2*count for both levels, compares and waits in the decision step while the previous
// result beat sits unaccepted. samples stall until the sequencer is idle again, so a waiting
// result beat holds up the following frame. writing 0 to hold_frames or min_on_frames stores
// 1; configuration is to be written while the block is idle, which the block does not enforce.
module voice_activity_switch_rms #(
	parameter int unsigned FRAME_MAX = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_write,
	input  logic [vas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vas_pkg::DATA_W-1:0]         cfg_data,
	// sample channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [vas_pkg::DATA_W-1:0]  sample,
	input  logic                               frame_end,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               voice_on,
	output logic [31:0]                        activations,
	output logic                               frame_overflow
);
	import vas_pkg::*;

	// count width, multiplier operand width, product, sum and compare widths
	localparam int unsigned TW = $clog2(FRAME_MAX + 1);
	localparam int unsigned MB = (TW > 16) ? TW : 16;
	localparam int unsigned PW = 16 + MB;
	localparam int unsigned SW = 30 + TW;
	localparam int unsigned CW = 32 + TW;

	st_t state_q;

	// configuration registers
	logic [DATA_W-1:0] activate_q;
	logic [DATA_W-1:0] release_q;
	logic [DATA_W-1:0] hold_frames_q;
	logic [DATA_W-1:0] min_on_frames_q;

	// frame accumulators
	logic [SW-1:0] sum_q;
	logic [TW-1:0] tally_q;
	logic          ovf_q;

	// current sample
	logic [DATA_W-1:0] mag_q;
	logic              last_q;
	logic              counted_q;

	// shared multiplier and the level^2*count build-up
	logic [15:0]    mul_a;
	logic [MB-1:0]  mul_b;
	logic [PW-1:0]  prod_q;
	logic [15:0]    hi_q;
	logic [CW-1:0]  rhs_q;
	logic [CW-1:0]  rhs_full;
	logic [CW-1:0]  lhs;
	logic           above_q;
	logic           below_q;

	// switch state
	logic        active_q;
	logic [31:0] act_cnt_q;
	logic [15:0] min_left_q;
	logic [15:0] hold_left_q;

	logic        active_n;
	logic [31:0] act_cnt_n;
	logic [15:0] min_left_n;
	logic [15:0] hold_left_n;
	logic [15:0] min_dec;

	// result register
	logic        out_valid_q;
	logic        voice_on_q;
	logic [31:0] activations_q;
	logic        frame_overflow_q;

	logic in_take;
	logic out_free;
	logic dec_go;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign dec_go    = (state_q == ST_DEC) && out_free;

	assign out_valid      = out_valid_q;
	assign voice_on       = voice_on_q;
	assign activations    = activations_q;
	assign frame_overflow = frame_overflow_q;

	// sum of squares scaled by four against level^2 * count
	assign lhs      = {sum_q, 2'b00};
	assign rhs_full = rhs_q + (CW'(prod_q) << 16);

	// operand selection for the shared multiplier
	always_comb begin
		case (state_q)
			ST_SQ: begin
				mul_a = mag_q;
				mul_b = MB'(mag_q);
			end
			ST_A2: begin
				mul_a = activate_q;
				mul_b = MB'(activate_q);
			end
			ST_AC: begin
				mul_a = release_q;
				mul_b = MB'(release_q);
			end
			ST_AL, ST_RL: begin
				// low half of level^2 times the count
				mul_a = prod_q[15:0];
				mul_b = MB'(tally_q);
			end
			ST_AH, ST_RH: begin
				// high half of level^2 times the count
				mul_a = hi_q;
				mul_b = MB'(tally_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// hysteresis, minimum on-time and hangover rule
	always_comb begin
		active_n    = active_q;
		act_cnt_n   = act_cnt_q;
		min_left_n  = min_left_q;
		hold_left_n = hold_left_q;
		min_dec     = (min_left_q != '0) ? (min_left_q - 16'd1) : min_left_q;
		if (above_q) begin
			// activation wins when both tests hold
			if (!active_q) begin
				active_n   = 1'b1;
				act_cnt_n  = act_cnt_q + 32'd1;
				min_left_n = min_on_frames_q;
			end
			hold_left_n = hold_frames_q;
		end else if (below_q) begin
			if (active_q) begin
				min_left_n = min_dec;
				if (min_dec == '0) begin
					if (hold_left_q != '0) begin
						hold_left_n = hold_left_q - 16'd1;
					end else begin
						active_n = 1'b0;
					end
				end
			end
		end else if (active_q) begin
			min_left_n = min_dec;
		end
	end

	// configuration writes, zero in a frame count stores one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			activate_q      <= '0;
			release_q       <= '0;
			hold_frames_q   <= 16'd1;
			min_on_frames_q <= 16'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ACTIVATE: activate_q <= cfg_data;
				REG_RELEASE:  release_q  <= cfg_data;
				REG_HOLD:     hold_frames_q   <= (cfg_data != '0) ? cfg_data : 16'd1;
				REG_MIN_ON:   min_on_frames_q <= (cfg_data != '0) ? cfg_data : 16'd1;
				default: begin
				end
			endcase
		end
	end

	// sequencer, accumulators and switch state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sum_q       <= '0;
			tally_q     <= '0;
			ovf_q       <= 1'b0;
			active_q    <= 1'b0;
			act_cnt_q   <= '0;
			min_left_q  <= '0;
			hold_left_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= ST_SQ;
						if (tally_q < TW'(FRAME_MAX)) begin
							tally_q <= tally_q + TW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
				end
				ST_SQ: state_q <= ST_ADD;
				ST_ADD: begin
					if (counted_q) begin
						sum_q <= sum_q + SW'(prod_q);
					end
					state_q <= last_q ? ST_A2 : ST_IDLE;
				end
				ST_A2: state_q <= ST_AL;
				ST_AL: state_q <= ST_AH;
				ST_AH: state_q <= ST_AC;
				ST_AC: state_q <= ST_RL;
				ST_RL: state_q <= ST_RH;
				ST_RH: state_q <= ST_RC;
				ST_RC: state_q <= ST_DEC;
				ST_DEC: begin
					// hold the decision until the result register is free
					if (out_free) begin
						active_q    <= active_n;
						act_cnt_q   <= act_cnt_n;
						min_left_q  <= min_left_n;
						hold_left_q <= hold_left_n;
						sum_q       <= '0;
						tally_q     <= '0;
						ovf_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= PW'(mul_a) * PW'(mul_b);
		if (in_take) begin
			// magnitude, -32768 gives 32768 in 16 unsigned bits
			mag_q     <= sample[DATA_W-1] ? DATA_W'(-sample) : DATA_W'(sample);
			last_q    <= frame_end;
			counted_q <= (tally_q < TW'(FRAME_MAX));
		end
		if ((state_q == ST_AL) || (state_q == ST_RL)) begin
			hi_q <= prod_q[31:16];
		end
		if ((state_q == ST_AH) || (state_q == ST_RH)) begin
			rhs_q <= CW'(prod_q);
		end
		if (state_q == ST_AC) begin
			above_q <= (lhs > rhs_full);
		end
		if (state_q == ST_RC) begin
			below_q <= (lhs < rhs_full);
		end
	end

	// result register, takes a new beat while the old one leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dec_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_go) begin
			voice_on_q       <= active_n;
			activations_q    <= act_cnt_n;
			frame_overflow_q <= ovf_q;
		end
	end

	// a result beat only starts out of the decision step
	a_beat_from_dec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DEC))
		else $error("result beat without a frame decision");

	// the frame count never passes its limit
	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TW'(FRAME_MAX))
		else $error("sample count beyond frame limit");

	// an inactive switch has no minimum on-time left
	a_min_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (min_left_q == '0))
		else $error("minimum on-time running while inactive");

	// an accepted sample always goes on to be squared
	a_take_to_sq: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == ST_SQ))
		else $error("accepted sample not squared");

endmodule
